// File: rtl/htpr_pkg.sv
// shared types and constants for the probing hash table
package htpr_pkg;

   localparam int unsigned TableEntriesDefault = 4095;
   localparam int unsigned ProbeSpanDefault    = 4;
   localparam logic [3:0]  AgeLimitReset       = 4'd2;
   localparam logic [3:0]  AgeMax              = 4'd15;
   localparam logic [31:0] NullMove            = 32'd0;

   typedef enum logic [1:0] {
      KIND_STORE = 2'd0,
      KIND_PROBE = 2'd1,
      KIND_AGE   = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] key;
      logic [7:0]  depth;
      logic [1:0]  bound;
      logic [63:0] score;
      logic [31:0] move;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        stored;
      logic [7:0]  found_depth;
      logic [1:0]  found_bound;
      logic [3:0]  found_age;
      logic [63:0] found_score;
      logic [31:0] found_move;
   } rsp_type;

   typedef struct packed {
      logic        used;
      logic [63:0] key;
      logic [7:0]  depth;
      logic [1:0]  bound;
      logic [3:0]  age;
      logic [63:0] score;
      logic [31:0] move;
   } entry_type;

endpackage

// File: rtl/htpr_mod.sv
// key modulo an odd table size: folding at 32 bits, then a reciprocal multiply
module htpr_mod
   import htpr_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
   parameter int unsigned IW = $clog2(TABLE_ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   key,
   output logic          done,
   output logic [IW-1:0] home
);

   localparam logic [63:0] ModWide   = 64'(TABLE_ENTRIES);
   localparam logic [63:0] FoldWide  = (64'd1 << 32) % ModWide;
   localparam logic [31:0] Fold32    = FoldWide[31:0];
   localparam int unsigned QShift    = 32 + IW;
   localparam logic [63:0] MagicWide = ((64'd1 << QShift) + ModWide - 64'd1) / ModWide;
   localparam logic [32:0] Magic     = MagicWide[32:0];
   localparam logic [31:0] Mod32     = ModWide[31:0];

   typedef enum logic [2:0] {
      MS_IDLE = 3'b001,
      MS_FOLD = 3'b010,
      MS_SUB  = 3'b100
   } mod_state_type;

   mod_state_type state_ff, state_in;
   logic [63:0]   val_ff, val_in;
   logic [64:0]   recip_ff, recip_in;
   logic [IW-1:0] rem_ff, rem_in;
   logic          done_ff, done_in;
   logic [63:0]   fold_sum;
   logic [64:0]   quot;
   logic [31:0]   rem_full;

   always_comb begin
      state_in = state_ff;
      val_in   = val_ff;
      recip_in = recip_ff;
      rem_in   = rem_ff;
      done_in  = 1'b0;
      fold_sum = ({32'd0, val_ff[63:32]} * {32'd0, Fold32}) + {32'd0, val_ff[31:0]};
      quot     = recip_ff >> QShift;
      rem_full = val_ff[31:0] - quot[31:0] * Mod32;
      case (state_ff)
         MS_FOLD: begin
            // upper word times 2^32 mod m, until the value fits in one word
            if (val_ff[63:32] != 32'd0) begin
               val_in = fold_sum;
            end else begin
               recip_in = {33'd0, val_ff[31:0]} * {32'd0, Magic};
               state_in = MS_SUB;
            end
         end
         MS_SUB: begin
            rem_in   = rem_full[IW-1:0];
            done_in  = 1'b1;
            state_in = MS_IDLE;
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase
      if (start) begin
         val_in   = key;
         state_in = MS_FOLD;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      recip_ff <= recip_in;
      rem_ff   <= rem_in;
      if (reset) begin
         state_ff <= MS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

// File: rtl/htpr_mem.sv
// slot memory with one read and one write port, registered read data
module htpr_mem
   import htpr_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
   parameter int unsigned IW = $clog2(TABLE_ENTRIES)
) (
   input  logic          clock,
   input  logic [IW-1:0] rd_addr,
   output entry_type     rd_data,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  entry_type     wr_data
);

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hash_table_probe_replace.sv
// Keyed table with linear probing. One request in flight at a time. After reset a clearing
// pass over every slot runs before the first request is taken. To find the home slot, the
// key is folded at 32 bits until it fits in one word, then reduced by a reciprocal multiply.
// Store and probe then read the span one slot per cycle through the single read port of the
// slot memory, and a store afterwards writes its entry into the slot it picked, if any. An
// age tick reads and writes back every slot, and a clear writes every slot empty. The result
// is handed over to its own output register and waits there, so the next request can be
// taken in the cycle after the hand-over even while that result is still stalled.
module hash_table_probe_replace
   import htpr_pkg::*;
#(
   parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
   parameter int unsigned PROBE_SPAN    = ProbeSpanDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [3:0] csr_wdata
);

   localparam int unsigned IW = $clog2(TABLE_ENTRIES);
   localparam int unsigned SW = $clog2(PROBE_SPAN + 1);
   localparam logic [IW-1:0] LastSlot = IW'(TABLE_ENTRIES - 1);
   localparam logic [SW-1:0] SpanCount = SW'(PROBE_SPAN);

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b00000001,
      ST_IDLE  = 8'b00000010,
      ST_HASH  = 8'b00000100,
      ST_SCAN  = 8'b00001000,
      ST_PASS2 = 8'b00010000,
      ST_AGERD = 8'b00100000,
      ST_AGEWR = 8'b01000000,
      ST_OUT   = 8'b10000000
   } state_type;

   state_type     state_ff, state_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   rsp_type       out_ff, out_in;
   logic          out_valid_ff, out_valid_in;
   logic [3:0]    limit_ff;
   logic [IW-1:0] addr_ff, addr_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic          rd_pend_ff, rd_pend_in;
   logic [IW-1:0] rd_slot_ff, rd_slot_in;
   logic          got_ff, got_in;
   logic [IW-1:0] pick_ff, pick_in;
   logic          deep_ff, deep_in;
   logic [IW-1:0] deep_slot_ff, deep_slot_in;

   logic          hash_start, hash_done;
   logic [IW-1:0] hash_home;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_data, rd_data, empty_entry, new_entry;
   logic          accept;

   function automatic logic [IW-1:0] step(input logic [IW-1:0] i);
      return (i == LastSlot) ? '0 : IW'(i + 1'b1);
   endfunction

   htpr_mod #(.TABLE_ENTRIES(TABLE_ENTRIES), .IW(IW)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   (req_ff.key),
      .done  (hash_done),
      .home  (hash_home)
   );

   htpr_mem #(.TABLE_ENTRIES(TABLE_ENTRIES), .IW(IW)) u_mem (
      .clock   (clock),
      .rd_addr (addr_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      empty_entry       = '0;
      empty_entry.move  = NullMove;
      new_entry.used    = 1'b1;
      new_entry.key     = req_ff.key;
      new_entry.depth   = req_ff.depth;
      new_entry.bound   = req_ff.bound;
      new_entry.age     = 4'd0;
      new_entry.score   = req_ff.score;
      new_entry.move    = req_ff.move;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      rd_slot_in   = addr_ff;
      got_in       = got_ff;
      pick_in      = pick_ff;
      deep_in      = deep_ff;
      deep_slot_in = deep_slot_ff;
      hash_start   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = empty_entry;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            addr_in = step(addr_ff);
            if (addr_ff == LastSlot) begin
               state_in = (req_ff.kind == KIND_CLEAR) ? ST_OUT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               req_in                = req_data;
               rsp_in                = '0;
               rsp_in.found_move     = NullMove;
               addr_in               = '0;
               cnt_in                = '0;
               case (kind_type'(req_data.kind))
                  KIND_STORE, KIND_PROBE: begin
                     state_in = ST_HASH;
                  end
                  KIND_AGE: begin
                     state_in = ST_AGERD;
                  end
                  default: begin
                     state_in = ST_CLEAR;
                  end
               endcase
            end
         end
         ST_HASH: begin
            hash_start = !hash_done && (cnt_ff != SpanCount);
            cnt_in     = SpanCount;
            if (hash_done) begin
               addr_in  = hash_home;
               cnt_in   = '0;
               got_in   = 1'b0;
               deep_in  = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue reads while counting, evaluate the returning data in the following cycle
            if (cnt_ff != SpanCount && !got_ff) begin
               rd_pend_in = 1'b1;
               rd_slot_in = addr_ff;
               addr_in    = step(addr_ff);
               cnt_in     = SW'(cnt_ff + 1'b1);
            end
            if (rd_pend_ff && !got_ff) begin
               if (req_ff.kind == KIND_PROBE) begin
                  if ((rd_data.used ? rd_data.key : 64'd0) == req_ff.key) begin
                     got_in                   = 1'b1;
                     rsp_in.hit               = 1'b1;
                     rsp_in.found_depth       = rd_data.used ? rd_data.depth : 8'd0;
                     rsp_in.found_bound       = rd_data.used ? rd_data.bound : 2'd0;
                     rsp_in.found_age         = rd_data.used ? rd_data.age : 4'd0;
                     rsp_in.found_score       = rd_data.used ? rd_data.score : 64'd0;
                     rsp_in.found_move        = rd_data.used ? rd_data.move : NullMove;
                  end
               end else begin
                  if (!rd_data.used || rd_data.key == 64'd0 || rd_data.key == req_ff.key
                      || rd_data.age >= limit_ff) begin
                     got_in  = 1'b1;
                     pick_in = rd_slot_ff;
                  end else if (!deep_ff && rd_data.depth < req_ff.depth) begin
                     deep_in      = 1'b1;
                     deep_slot_in = rd_slot_ff;
                  end
               end
            end
            if (got_ff || (cnt_ff == SpanCount && !rd_pend_ff)) begin
               state_in = (req_ff.kind == KIND_STORE) ? ST_PASS2 : ST_OUT;
            end
         end
         ST_PASS2: begin
            if (got_ff || deep_ff) begin
               wr_en         = 1'b1;
               wr_addr       = got_ff ? pick_ff : deep_slot_ff;
               wr_data       = new_entry;
               rsp_in.stored = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_AGERD: begin
            state_in = ST_AGEWR;
         end
         ST_AGEWR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (rd_data.used && rd_data.key != 64'd0 && rd_data.age != AgeMax) begin
               wr_data.age = rd_data.age + 4'd1;
            end
            addr_in  = step(addr_ff);
            state_in = (addr_ff == LastSlot) ? ST_OUT : ST_AGERD;
         end
         ST_OUT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_in       = rsp_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      out_ff       <= out_in;
      rd_slot_ff   <= rd_slot_in;
      pick_ff      <= pick_in;
      deep_slot_ff <= deep_slot_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_ff       <= '0;
         out_valid_ff <= 1'b0;
         addr_ff      <= '0;
         cnt_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         got_ff       <= 1'b0;
         deep_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ff       <= req_in;
         out_valid_ff <= out_valid_in;
         addr_ff      <= addr_in;
         cnt_ff       <= cnt_in;
         rd_pend_ff   <= rd_pend_in;
         got_ff       <= got_in;
         deep_ff      <= deep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= AgeLimitReset;
      end else if (csr_write) begin
         limit_ff <= csr_wdata;
      end
   end

endmodule

// File: verif/tb_top.sv
// testbench for the probing hash table: directed and random requests checked against a local table predictor
`timescale 1ns / 100ps

module tb_top;
   import htpr_pkg::*;

   localparam int unsigned Slots = TableEntriesDefault;
   localparam int unsigned Span  = ProbeSpanDefault;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_write = 1'b0;
   logic [3:0] csr_wdata = '0;

   hash_table_probe_replace uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // table copy and register copy
   logic [63:0] tab_key   [Slots];
   logic [7:0]  tab_depth [Slots];
   logic [1:0]  tab_bound [Slots];
   logic [3:0]  tab_age   [Slots];
   logic [63:0] tab_score [Slots];
   logic [31:0] tab_move  [Slots];
   logic [3:0]  age_limit = AgeLimitReset;

   req_type     request_q [$];
   rsp_type     lookup_q  [$];
   logic [63:0] key_pool  [$];

   int send_idle_pct = 13;
   int recv_idle_pct = 45;
   int errors = 0;
   int n_stored = 0, n_hits = 0, n_ticks = 0, n_clears = 0, n_results = 0;

   function automatic int unsigned next_idx(int unsigned i);
      return (i + 1 >= Slots) ? 0 : i + 1;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < Slots; i++) begin
         tab_key[i] = '0; tab_depth[i] = '0; tab_bound[i] = '0;
         tab_age[i] = '0; tab_score[i] = '0; tab_move[i] = NullMove;
      end
   endfunction

   function automatic rsp_type table_apply(req_type r);
      rsp_type     res;
      int unsigned idx;
      int unsigned home;
      bit          found;
      res = '0;
      res.found_move = NullMove;
      home = int'(r.key % 64'(Slots));
      found = 0;
      case (kind_type'(r.kind))
         KIND_STORE: begin
            idx = home;
            for (int n = 0; n < Span && !found; n++) begin
               if (tab_key[idx] == '0 || tab_key[idx] == r.key || tab_age[idx] >= age_limit)
                  found = 1;
               else
                  idx = next_idx(idx);
            end
            if (!found) begin
               idx = home;
               for (int n = 0; n < Span && !found; n++) begin
                  if (tab_depth[idx] < r.depth) found = 1;
                  else idx = next_idx(idx);
               end
            end
            if (found) begin
               tab_key[idx] = r.key; tab_depth[idx] = r.depth; tab_bound[idx] = r.bound;
               tab_age[idx] = '0; tab_score[idx] = r.score; tab_move[idx] = r.move;
               res.stored = 1'b1;
            end
         end
         KIND_PROBE: begin
            idx = home;
            for (int n = 0; n < Span && !found; n++) begin
               if (tab_key[idx] == r.key) begin
                  found = 1;
                  res.hit = 1'b1;
                  res.found_depth = tab_depth[idx];
                  res.found_bound = tab_bound[idx];
                  res.found_age   = tab_age[idx];
                  res.found_score = tab_score[idx];
                  res.found_move  = tab_move[idx];
               end else begin
                  idx = next_idx(idx);
               end
            end
         end
         KIND_AGE: begin
            for (int i = 0; i < Slots; i++)
               if (tab_key[i] != '0 && tab_age[i] < AgeMax) tab_age[i] = tab_age[i] + 1'b1;
         end
         default: wipe_table();
      endcase
      return res;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) lookup_q.push_back(table_apply(req_data));
         if (!req_valid || !req_stall) begin
            if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= request_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic field_check(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // receiver
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lookup_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
            end else begin
               want = lookup_q.pop_front();
               n_results++;
               n_stored += int'(want.stored);
               n_hits += int'(want.hit);
               field_check("hit", 64'(want.hit), 64'(rsp_data.hit));
               field_check("stored", 64'(want.stored), 64'(rsp_data.stored));
               field_check("found_depth", 64'(want.found_depth), 64'(rsp_data.found_depth));
               field_check("found_bound", 64'(want.found_bound), 64'(rsp_data.found_bound));
               field_check("found_age", 64'(want.found_age), 64'(rsp_data.found_age));
               field_check("found_score", want.found_score, rsp_data.found_score);
               field_check("found_move", 64'(want.found_move), 64'(rsp_data.found_move));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // key landing on a chosen home slot, high bits random
   function automatic logic [63:0] key_at(int unsigned home);
      logic [63:0] m;
      m = rand64() >> 12;
      return m * 64'(Slots) + 64'(home);
   endfunction

   task automatic add_request(kind_type k, logic [63:0] key, logic [7:0] depth);
      req_type r;
      r.kind = k;
      r.key = key;
      r.depth = depth;
      r.bound = 2'($urandom_range(3));
      r.score = rand64();
      r.move = $urandom;
      request_q.push_back(r);
      if (k == KIND_AGE) n_ticks++;
      if (k == KIND_CLEAR) n_clears++;
   endtask

   function automatic int unsigned pick_home();
      case ($urandom_range(4))
         0: return 0;
         1: return Slots - 1;
         2: return Slots - 2;
         3: return 17;
         default: return $urandom_range(Slots - 1);
      endcase
   endfunction

   function automatic logic [7:0] pick_depth();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [63:0] pool_key();
      if (key_pool.size() == 0 || $urandom_range(9) == 0) return rand64();
      return key_pool[$urandom_range(key_pool.size() - 1)];
   endfunction

   task automatic gen_random(int count);
      int          made;
      int unsigned home;
      logic [63:0] k;
      int          pick;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // burst of stores and probes around one bucket
            home = pick_home();
            repeat ($urandom_range(6, 3)) begin
               if ($urandom_range(2) == 0 && key_pool.size() > 0) begin
                  add_request(KIND_PROBE, pool_key(), pick_depth());
               end else begin
                  k = ($urandom_range(3) == 0 && key_pool.size() > 0) ? pool_key() : key_at(home);
                  key_pool.push_back(k);
                  add_request(KIND_STORE, k, pick_depth());
               end
               made++;
            end
         end else if (pick < 92) begin
            add_request(kind_type'($urandom_range(1)), pool_key(), pick_depth());
            made++;
         end else if (pick < 98) begin
            add_request(KIND_AGE, rand64(), pick_depth());
            made++;
         end else begin
            add_request(KIND_CLEAR, rand64(), pick_depth());
            made++;
         end
         if (key_pool.size() > 64) void'(key_pool.pop_front());
      end
   endtask

   task automatic drain();
      while (request_q.size() != 0 || req_valid || lookup_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [3:0] v);
      drain();
      csr_write <= 1'b1;
      csr_wdata <= v;
      age_limit = v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      logic [63:0] k;
      logic [3:0]  limits [6];
      wipe_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, each kind, zero key, empty-slot probe, ageing and clear
      add_request(KIND_PROBE, 64'd0, 8'd0);
      add_request(KIND_PROBE, 64'd5, 8'd0);
      add_request(KIND_STORE, '1, 8'd255);
      add_request(KIND_PROBE, '1, 8'd0);
      add_request(KIND_STORE, 64'd0, 8'd9);
      add_request(KIND_PROBE, 64'd0, 8'd0);
      add_request(KIND_STORE, 64'd0, 8'd3);
      k = key_at(Slots - 1);
      for (int i = 0; i < 5; i++) add_request(KIND_STORE, k + 64'(i * Slots), 8'(100 + i));
      add_request(KIND_STORE, k + 64'(9 * Slots), 8'd0);
      add_request(KIND_STORE, k + 64'(10 * Slots), 8'd255);
      add_request(KIND_PROBE, k + 64'(10 * Slots), 8'd0);
      add_request(KIND_AGE, 64'd0, 8'd0);
      add_request(KIND_AGE, 64'd0, 8'd0);
      add_request(KIND_PROBE, k + 64'(Slots), 8'd0);
      add_request(KIND_STORE, k + 64'(20 * Slots), 8'd1);
      add_request(KIND_PROBE, k + 64'(20 * Slots), 8'd0);
      add_request(KIND_CLEAR, '1, 8'd255);
      add_request(KIND_PROBE, k, 8'd0);
      begin
         req_type r;
         r = '1;
         r.kind = KIND_STORE;
         request_q.push_back(r);
         r.kind = KIND_PROBE;
         request_q.push_back(r);
      end

      limits = '{4'd0, 4'd15, 4'd2, 4'd1, 4'd0, 4'd0};
      limits[4] = 4'($urandom_range(15));
      limits[5] = 4'($urandom_range(15));
      for (int p = 0; p < 6; p++) begin
         write_limit(limits[p]);
         if (p < 2) begin
            send_idle_pct = 13; recv_idle_pct = 45;
         end else if (p < 4) begin
            send_idle_pct = 45; recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         if (p == 1) begin
            // age saturation
            k = key_at(pick_home());
            add_request(KIND_STORE, k, 8'd50);
            repeat (16) add_request(KIND_AGE, 64'd0, 8'd0);
            add_request(KIND_PROBE, k, 8'd0);
            add_request(KIND_STORE, key_at(int'(k % 64'(Slots))), 8'd0);
         end
         gen_random(72);
      end

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d responses: %0d stores written, %0d probe hits", n_results,
               n_stored, n_hits);
      $display("%0d age ticks and %0d clears across six replacement limits", n_ticks,
               n_clears);
      if (errors == 0 && lookup_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("timeout waiting for responses");
      $display("Simulation FAILED");
      $finish;
   end

endmodule
